// ----- sv/wf3x3_pkg.sv -----
// ----------------------------------------------------------------------------
// wf3x3_pkg
// Shared constants, codes and types of the 3x3 window filter.
// ----------------------------------------------------------------------------
package wf3x3_pkg;

  localparam int unsigned MaxWidth  = 2048;
  localparam int unsigned MaxHeight = 2048;

  localparam int unsigned ColW     = $clog2(MaxWidth);
  localparam int unsigned RowW     = $clog2(MaxHeight);
  localparam int unsigned SizeW    = 12;
  localparam int unsigned PixW     = 8;
  localparam int unsigned PosW     = 11;
  localparam int unsigned ModeW    = 3;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 12;
  localparam int unsigned WinCells = 9;

  localparam logic [PixW-1:0]  EdgeThreshRst = PixW'(50);
  localparam logic [SizeW-1:0] WidthRst      = SizeW'(640);
  localparam logic [SizeW-1:0] HeightRst     = SizeW'(480);

  localparam int unsigned SumW      = 12;
  localparam int unsigned RecipW    = 13;
  localparam int unsigned ProdW     = SumW + RecipW;
  localparam int unsigned MeanShift = 16;
  localparam logic [RecipW-1:0] MeanRecip = RecipW'(7282);

  localparam int unsigned OutDepth = 8;
  localparam int unsigned OutPtrW  = $clog2(OutDepth);
  localparam int unsigned OutCntW  = $clog2(OutDepth + 1);

  typedef enum logic [CfgIdxW-1:0] {
    RegMode   = 2'd0,
    RegThresh = 2'd1,
    RegWidth  = 2'd2,
    RegHeight = 2'd3
  } cfg_reg_e;

  typedef enum logic [ModeW-1:0] {
    ModeMax    = 3'd0,
    ModeMin    = 3'd1,
    ModeEdge   = 3'd2,
    ModeMean   = 3'd3,
    ModeMedian = 3'd4
  } filter_mode_e;

  typedef logic [WinCells-1:0][PixW-1:0] window_t;

  typedef struct packed {
    logic            valid;
    logic [PosW-1:0] row;
    logic [PosW-1:0] col;
    logic            done;
  } meta_t;

  typedef struct packed {
    logic [PosW-1:0] row;
    logic [PosW-1:0] col;
    logic [PixW-1:0] value;
    logic            done;
  } result_t;

endpackage

// ----- sv/window_filter_3x3.sv -----
// ----------------------------------------------------------------------------
// window_filter_3x3
// 3x3 sliding-window filter over a raster stream of 8-bit grey pixels.
// ----------------------------------------------------------------------------
// Pixels enter in raster order on the input channel, one beat per pixel;
// frame_start on a beat puts that pixel at row 0, column 0. For every
// interior pixel one beat leaves on the output channel with its row, its
// column, the filtered value and frame_done on the last one of the frame.
// Border pixels produce no beat. The mode, threshold and frame size are
// written through the configuration channel, by the user only while the
// block is idle; the block does not enforce this. One pixel is accepted per
// cycle while input ready is high. The result for the pixel that completes
// its window passes the line-store read, the window shift, two kernel stages
// and the output queue. The two line stores are memories read and written
// once per pixel, which sets the rate of one pixel per cycle. An eight-beat
// output queue absorbs receiver stalls; input ready drops only when eight
// results are queued or in flight. Reset restores the default registers,
// clears the window, the position and the queue, but not the line stores.
// ----------------------------------------------------------------------------
module window_filter_3x3 import wf3x3_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [PixW-1:0]     pixel_i,
  input  logic                frame_start_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [PosW-1:0]     out_row_o,
  output logic [PosW-1:0]     out_col_o,
  output logic [PixW-1:0]     value_o,
  output logic                frame_done_o
);

  function automatic logic [SizeW-1:0] clamp_size(input logic [SizeW-1:0] v,
                                                  input logic [SizeW-1:0] hi);
    if (v < SizeW'(3)) begin
      return SizeW'(3);
    end
    if (v > hi) begin
      return hi;
    end
    return v;
  endfunction

  logic [ModeW-1:0] mode_q;
  logic [PixW-1:0]  thresh_q;
  logic [SizeW-1:0] width_q, height_q;

  logic            in_acc, pop, push;
  logic [ColW-1:0] col_q, cur_col, nxt_col;
  logic [RowW-1:0] row_q, cur_row, nxt_row;
  logic            emit, done;

  logic             s1_valid_q, s1_emit_q, s1_done_q;
  logic [ColW-1:0]  s1_col_q;
  logic [RowW-1:0]  s1_row_q;
  logic [PixW-1:0]  s1_px_q;
  logic             fwd_q;
  logic [PixW-1:0]  fwd_top_q, fwd_mid_q;
  logic [PixW-1:0]  older_rd, newer_rd, top1, mid1;

  window_t win_q;
  meta_t   meta_w_q, kmeta;
  logic [PixW-1:0] kvalue;

  result_t              fifo_q [OutDepth];
  logic [OutPtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [OutCntW-1:0]   fcnt_q, resv_q;
  result_t              head;

  // Configuration registers.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= ModeMax;
      thresh_q <= EdgeThreshRst;
      width_q  <= WidthRst;
      height_q <= HeightRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        RegMode:   mode_q   <= cfg_data_i[ModeW-1:0];
        RegThresh: thresh_q <= cfg_data_i[PixW-1:0];
        RegWidth:  width_q  <= clamp_size(cfg_data_i[SizeW-1:0], SizeW'(MaxWidth));
        RegHeight: height_q <= clamp_size(cfg_data_i[SizeW-1:0], SizeW'(MaxHeight));
        default:   ;
      endcase
    end
  end

  // Position of the incoming pixel and of the next one.
  always_comb begin
    logic [SizeW-1:0] c_ext, r_ext, c_nxt, r_nxt;
    c_ext = frame_start_i ? '0 : SizeW'(col_q);
    r_ext = frame_start_i ? '0 : SizeW'(row_q);
    if (c_ext >= width_q) begin
      c_ext = '0;
      r_ext = r_ext + SizeW'(1);
    end
    if (r_ext >= height_q) begin
      r_ext = '0;
    end
    cur_col = ColW'(c_ext);
    cur_row = RowW'(r_ext);
    emit    = (r_ext >= SizeW'(2)) && (c_ext >= SizeW'(2));
    done    = (r_ext == height_q - SizeW'(1)) && (c_ext == width_q - SizeW'(1));
    c_nxt   = c_ext + SizeW'(1);
    r_nxt   = r_ext + SizeW'(1);
    if (c_nxt >= width_q) begin
      nxt_col = '0;
      nxt_row = (r_nxt >= height_q) ? '0 : RowW'(r_nxt);
    end else begin
      nxt_col = ColW'(c_nxt);
      nxt_row = cur_row;
    end
  end

  assign in_ready_o = (resv_q < OutCntW'(OutDepth));
  assign in_acc     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_acc) begin
      col_q <= nxt_col;
      row_q <= nxt_row;
    end
  end

  // Line stores: read on accept, written back in the following cycle.
  wf3x3_ram #(
    .Width (PixW),
    .Depth (MaxWidth)
  ) u_older_line (
    .clk_i   (clk_i),
    .we_i    (s1_valid_q),
    .waddr_i (s1_col_q),
    .wdata_i (mid1),
    .re_i    (in_acc),
    .raddr_i (cur_col),
    .rdata_o (older_rd)
  );

  wf3x3_ram #(
    .Width (PixW),
    .Depth (MaxWidth)
  ) u_newer_line (
    .clk_i   (clk_i),
    .we_i    (s1_valid_q),
    .waddr_i (s1_col_q),
    .wdata_i (s1_px_q),
    .re_i    (in_acc),
    .raddr_i (cur_col),
    .rdata_o (newer_rd)
  );

  // A read of the column being written in the same cycle takes the new data.
  assign top1 = fwd_q ? fwd_top_q : older_rd;
  assign mid1 = fwd_q ? fwd_mid_q : newer_rd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      fwd_q      <= 1'b0;
    end else begin
      s1_valid_q <= in_acc;
      if (in_acc) begin
        fwd_q <= s1_valid_q && (s1_col_q == cur_col);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_col_q  <= cur_col;
      s1_row_q  <= cur_row;
      s1_px_q   <= pixel_i;
      s1_emit_q <= emit;
      s1_done_q <= done;
      fwd_top_q <= mid1;
      fwd_mid_q <= s1_px_q;
    end
  end

  // Window shift and the tag of the pixel it is centered on.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q    <= '0;
      meta_w_q <= '0;
    end else begin
      meta_w_q.valid <= s1_valid_q && s1_emit_q;
      meta_w_q.row   <= PosW'(s1_row_q - RowW'(1));
      meta_w_q.col   <= PosW'(s1_col_q - ColW'(1));
      meta_w_q.done  <= s1_done_q;
      if (s1_valid_q) begin
        win_q <= {s1_px_q, win_q[8], win_q[7],
                  mid1,    win_q[5], win_q[4],
                  top1,    win_q[2], win_q[1]};
      end
    end
  end

  wf3x3_kernel u_kernel (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .win_i    (win_q),
    .meta_i   (meta_w_q),
    .mode_i   (mode_q),
    .thresh_i (thresh_q),
    .value_o  (kvalue),
    .meta_o   (kmeta)
  );

  // Output queue with a reservation count that covers results in flight.
  assign push = kmeta.valid;
  assign pop  = out_valid_o && out_ready_i;
  assign head = fifo_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fcnt_q   <= '0;
      resv_q   <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + OutPtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + OutPtrW'(1);
      end
      fcnt_q <= fcnt_q + OutCntW'(push) - OutCntW'(pop);
      resv_q <= resv_q + OutCntW'(in_acc && emit) - OutCntW'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= '{row: kmeta.row, col: kmeta.col, value: kvalue, done: kmeta.done};
    end
  end

  assign out_valid_o  = (fcnt_q != '0);
  assign out_row_o    = head.row;
  assign out_col_o    = head.col;
  assign value_o      = head.value;
  assign frame_done_o = head.done;

endmodule

// ----- sv/wf3x3_ram.sv -----
// ----------------------------------------------------------------------------
// wf3x3_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module wf3x3_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/wf3x3_kernel.sv -----
// ----------------------------------------------------------------------------
// wf3x3_kernel
// Pipelined evaluation of the nine-cell window: row sorts, max, min, mean
// and median, then the edge test and the selection by filter mode.
// ----------------------------------------------------------------------------
module wf3x3_kernel import wf3x3_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  window_t          win_i,
  input  meta_t            meta_i,
  input  logic [ModeW-1:0] mode_i,
  input  logic [PixW-1:0]  thresh_i,
  output logic [PixW-1:0]  value_o,
  output meta_t            meta_o
);

  function automatic logic [2:0][PixW-1:0] sort3(input logic [PixW-1:0] a,
                                                 input logic [PixW-1:0] b,
                                                 input logic [PixW-1:0] c);
    logic [PixW-1:0] x0, x1, x2, t;
    x0 = a;
    x1 = b;
    x2 = c;
    if (x0 > x1) begin
      t = x0; x0 = x1; x1 = t;
    end
    if (x1 > x2) begin
      t = x1; x1 = x2; x2 = t;
    end
    if (x0 > x1) begin
      t = x0; x0 = x1; x1 = t;
    end
    return {x2, x1, x0};
  endfunction

  logic [2:0][PixW-1:0] lo_d, md_d, hi_d, lo_q, md_q, hi_q;
  logic [SumW-1:0]      sum_d, sum_q;
  meta_t                meta_a_q;

  logic [2:0][PixW-1:0] s_lo, s_md, s_hi, s_mx, s_mn;
  logic [PixW-1:0]      maxlo_q, medmid_q, minhi_q, mx_q, mn_q;
  logic [ProdW-1:0]     prod_q;
  meta_t                meta_b_q;

  logic [2:0][PixW-1:0] s_med;
  logic [PixW-1:0]      range;

  always_comb begin
    logic [2:0][PixW-1:0] s;
    for (int k = 0; k < 3; k++) begin
      s = sort3(win_i[3*k], win_i[3*k+1], win_i[3*k+2]);
      lo_d[k] = s[0];
      md_d[k] = s[1];
      hi_d[k] = s[2];
    end
    sum_d = ((SumW'(win_i[0]) + SumW'(win_i[1])) + (SumW'(win_i[2]) + SumW'(win_i[3])))
          + ((SumW'(win_i[4]) + SumW'(win_i[5])) + (SumW'(win_i[6]) + SumW'(win_i[7])))
          + SumW'(win_i[8]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      meta_a_q <= '0;
    end else begin
      meta_a_q <= meta_i;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q  <= lo_d;
    md_q  <= md_d;
    hi_q  <= hi_d;
    sum_q <= sum_d;
  end

  always_comb begin
    s_lo = sort3(lo_q[0], lo_q[1], lo_q[2]);
    s_md = sort3(md_q[0], md_q[1], md_q[2]);
    s_hi = sort3(hi_q[0], hi_q[1], hi_q[2]);
    s_mx = s_hi;
    s_mn = s_lo;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      meta_b_q <= '0;
    end else begin
      meta_b_q <= meta_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    maxlo_q  <= s_lo[2];
    medmid_q <= s_md[1];
    minhi_q  <= s_hi[0];
    mx_q     <= s_mx[2];
    mn_q     <= s_mn[0];
    prod_q   <= ProdW'(sum_q) * ProdW'(MeanRecip);
  end

  always_comb begin
    s_med = sort3(maxlo_q, medmid_q, minhi_q);
    range = mx_q - mn_q;
    unique case (mode_i)
      ModeMax:    value_o = mx_q;
      ModeMin:    value_o = mn_q;
      ModeEdge:   value_o = (range > thresh_i) ? '1 : '0;
      ModeMean:   value_o = prod_q[MeanShift +: PixW];
      ModeMedian: value_o = s_med[1];
      default:    value_o = '0;
    endcase
  end

  assign meta_o = meta_b_q;

endmodule
